/* hdl/cborhd_pkg.sv */
// Shared constants and result type for the CBOR head decoder.
package cborhd_pkg;

    localparam int MAJOR_W = 3;
    localparam int INFO_W  = 5;
    localparam int ARG_W   = 64;
    localparam int CLASS_W = 4;
    localparam int ERR_W   = 2;
    localparam int LEFT_W  = 4;

    // Additional info codes.
    localparam logic [INFO_W-1:0] INFO_DIRECT_LIMIT = 5'd24;
    localparam logic [INFO_W-1:0] INFO_ARG1         = 5'd24;
    localparam logic [INFO_W-1:0] INFO_ARG2         = 5'd25;
    localparam logic [INFO_W-1:0] INFO_ARG4         = 5'd26;
    localparam logic [INFO_W-1:0] INFO_ARG8         = 5'd27;
    localparam logic [INFO_W-1:0] INFO_INDEFINITE   = 5'd31;
    localparam logic [INFO_W-1:0] INFO_FALSE        = 5'd20;
    localparam logic [INFO_W-1:0] INFO_TRUE         = 5'd21;
    localparam logic [INFO_W-1:0] INFO_NULL         = 5'd22;
    localparam logic [INFO_W-1:0] INFO_UNDEF        = 5'd23;

    // Major types that matter to the decoder.
    localparam logic [MAJOR_W-1:0] MAJOR_UINT   = 3'd0;
    localparam logic [MAJOR_W-1:0] MAJOR_NEGINT = 3'd1;
    localparam logic [MAJOR_W-1:0] MAJOR_TAG    = 3'd6;
    localparam logic [MAJOR_W-1:0] MAJOR_SIMPLE = 3'd7;

    localparam logic [ARG_W-1:0] SIMPLE_MIN = 64'd32;

    // Item classes.
    localparam logic [CLASS_W-1:0] CLS_BOOL   = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_NULL   = 4'd8;
    localparam logic [CLASS_W-1:0] CLS_UNDEF  = 4'd9;
    localparam logic [CLASS_W-1:0] CLS_SIMPLE = 4'd10;
    localparam logic [CLASS_W-1:0] CLS_FLOAT  = 4'd11;
    localparam logic [CLASS_W-1:0] CLS_DOUBLE = 4'd12;
    localparam logic [CLASS_W-1:0] CLS_BREAK  = 4'd13;
    localparam logic [CLASS_W-1:0] CLS_ERROR  = 4'd14;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RESERVED = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_INDEF = 2'd2;
    localparam logic [ERR_W-1:0] ERR_SIMPLE   = 2'd3;

    typedef struct packed {
        logic [CLASS_W-1:0] item_class;
        logic [ARG_W-1:0]   argument;
        logic [MAJOR_W-1:0] major_kind;
        logic [INFO_W-1:0]  extra_info;
        logic               indefinite;
        logic               bool_value;
        logic [ERR_W-1:0]   error_code;
    } result_t;

endpackage

/* hdl/cborhd_classify.sv */
// Classifies a complete head from its major type, additional info and argument.
module cborhd_classify
    import cborhd_pkg::*;
(
    input  logic [MAJOR_W-1:0] major,
    input  logic [INFO_W-1:0]  info,
    input  logic [ARG_W-1:0]   arg,
    output result_t            result
);

    always_comb
    begin
        result            = '0;
        result.major_kind = major;
        result.extra_info = info;
        result.error_code = ERR_NONE;
        // Major types 0 to 6 carry their type as the class.
        if (major != MAJOR_SIMPLE)
        begin
            result.item_class = {1'b0, major};
            if (info == INFO_INDEFINITE)
            begin
                result.indefinite = 1'b1;
            end
            else
            begin
                result.argument = arg;
            end
        end
        else
        begin
            // Simple values and floats.
            unique case (info)
                INFO_FALSE: result.item_class = CLS_BOOL;
                INFO_TRUE:
                begin
                    result.item_class = CLS_BOOL;
                    result.bool_value = 1'b1;
                end
                INFO_NULL:  result.item_class = CLS_NULL;
                INFO_UNDEF: result.item_class = CLS_UNDEF;
                INFO_ARG1:
                begin
                    if (arg < SIMPLE_MIN)
                    begin
                        result.item_class = CLS_ERROR;
                        result.error_code = ERR_SIMPLE;
                    end
                    else
                    begin
                        result.item_class = CLS_SIMPLE;
                        result.argument   = arg;
                    end
                end
                INFO_ARG2, INFO_ARG4:
                begin
                    result.item_class = CLS_FLOAT;
                    result.argument   = arg;
                end
                INFO_ARG8:
                begin
                    result.item_class = CLS_DOUBLE;
                    result.argument   = arg;
                end
                INFO_INDEFINITE: result.item_class = CLS_BREAK;
                default:
                begin
                    result.item_class = CLS_SIMPLE;
                    result.argument   = arg;
                end
            endcase
        end
    end

endmodule

/* hdl/cbor_head_decoder.sv */
// Top level of the CBOR head decoder: input register, byte sequencer, result register.
//
//   Channel | Signals                         | Direction
//   input   | in_valid, in_ready, in_byte     | in
//   result  | out_valid, out_ready, item_class,
//           | argument, major_kind, extra_info,
//           | indefinite, bool_value, error_code | out
//
// One byte item is accepted per cycle while in_ready is high. A byte is decoded
// from the input register against the head state, and a finished head is written
// to the result register when the decode stage advances on its last byte. A head
// takes one to nine bytes, set by its additional info.
// Reset clears the head state, so the block waits for an initial byte.
// A full result register that is not taken holds the input register, which
// then drops in_ready once it is occupied too.
module cbor_head_decoder
    import cborhd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CLASS_W-1:0] item_class,
    output logic [ARG_W-1:0]   argument,
    output logic [MAJOR_W-1:0] major_kind,
    output logic [INFO_W-1:0]  extra_info,
    output logic               indefinite,
    output logic               bool_value,
    output logic [ERR_W-1:0]   error_code
);

    logic               byte_valid_reg;
    logic [7:0]         byte_reg;
    logic [LEFT_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [MAJOR_W-1:0] held_major_reg, held_major_next;
    logic [INFO_W-1:0]  held_info_reg, held_info_next;
    logic [ARG_W-1:0]   arg_accum_reg, arg_accum_next;
    logic               out_valid_reg;
    result_t            res_reg, res_next;

    logic               advance;
    logic               emit;
    logic [MAJOR_W-1:0] cls_major;
    logic [INFO_W-1:0]  cls_info;
    logic [ARG_W-1:0]   cls_arg;
    result_t            cls_result;
    logic [MAJOR_W-1:0] byte_major;
    logic [INFO_W-1:0]  byte_info;

    // The decode stage moves when the result register is free or being taken.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !byte_valid_reg || advance;

    assign byte_major = byte_reg[7:5];
    assign byte_info  = byte_reg[4:0];

    // Classifier sees either the held initial byte or the new one.
    assign cls_major = (bytes_left_reg != '0) ? held_major_reg : byte_major;
    assign cls_info  = (bytes_left_reg != '0) ? held_info_reg : byte_info;
    assign cls_arg   = (bytes_left_reg != '0) ? {arg_accum_reg[ARG_W-9:0], byte_reg}
                                              : {{(ARG_W-INFO_W){1'b0}}, byte_info};

    cborhd_classify u_classify (
        .major  (cls_major),
        .info   (cls_info),
        .arg    (cls_arg),
        .result (cls_result)
    );

    // Head state update and result selection for the byte in the input register.
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        held_major_next = held_major_reg;
        held_info_next  = held_info_reg;
        arg_accum_next  = arg_accum_reg;
        res_next        = cls_result;
        emit            = 1'b0;
        if (bytes_left_reg != '0)
        begin
            arg_accum_next  = cls_arg;
            bytes_left_next = bytes_left_reg - 1'b1;
            emit            = (bytes_left_reg == LEFT_W'(1));
        end
        else
        begin
            held_major_next = byte_major;
            held_info_next  = byte_info;
            arg_accum_next  = '0;
            if (byte_info < INFO_DIRECT_LIMIT)
            begin
                emit = 1'b1;
            end
            else
            begin
                unique case (byte_info)
                    INFO_ARG1: bytes_left_next = LEFT_W'(1);
                    INFO_ARG2: bytes_left_next = LEFT_W'(2);
                    INFO_ARG4: bytes_left_next = LEFT_W'(4);
                    INFO_ARG8: bytes_left_next = LEFT_W'(8);
                    INFO_INDEFINITE:
                    begin
                        emit = 1'b1;
                        if (byte_major == MAJOR_UINT || byte_major == MAJOR_NEGINT ||
                            byte_major == MAJOR_TAG)
                        begin
                            res_next            = '0;
                            res_next.item_class = CLS_ERROR;
                            res_next.major_kind = byte_major;
                            res_next.extra_info = byte_info;
                            res_next.error_code = ERR_NOT_INDEF;
                        end
                    end
                    default:
                    begin
                        // Reserved additional info.
                        emit                = 1'b1;
                        res_next            = '0;
                        res_next.item_class = CLS_ERROR;
                        res_next.major_kind = byte_major;
                        res_next.extra_info = byte_info;
                        res_next.error_code = ERR_RESERVED;
                    end
                endcase
            end
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    // Head state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            held_major_reg <= '0;
            held_info_reg  <= '0;
            arg_accum_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= byte_valid_reg && emit;
            if (byte_valid_reg)
            begin
                bytes_left_reg <= bytes_left_next;
                held_major_reg <= held_major_next;
                held_info_reg  <= held_info_next;
                arg_accum_reg  <= arg_accum_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance && byte_valid_reg && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign item_class = res_reg.item_class;
    assign argument   = res_reg.argument;
    assign major_kind = res_reg.major_kind;
    assign extra_info = res_reg.extra_info;
    assign indefinite = res_reg.indefinite;
    assign bool_value = res_reg.bool_value;
    assign error_code = res_reg.error_code;

endmodule
